[hdl/srfc_pkg.sv]
// Shared types, constants and the CRC-16/Modbus byte update for the
// sensor reply frame checker. No dependencies.
package srfc_pkg;

   // Frame layout and CRC constants.
   localparam logic [15:0] CrcInit     = 16'hFFFF;
   localparam logic [15:0] CrcPolyRefl = 16'hA001;
   localparam logic [3:0]  CrcSpan     = 4'd6;
   localparam logic [3:0]  FrameLen    = 4'd8;
   localparam logic [3:0]  FirstReading = 4'd2;
   localparam logic [3:0]  LastByte    = 4'd7;
   localparam int          SignBit     = 7;

   // Status codes carried in frame_status.
   localparam logic FrameOk     = 1'b0;
   localparam logic FrameBadCrc = 1'b1;

   // One received byte and its start mark.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } srfc_item_type;

   // One checked frame.
   typedef struct packed {
      logic [15:0]        humidity_tenths;
      logic signed [15:0] temperature_tenths;
      logic               frame_status;
   } srfc_result_type;

   // Reflected CRC-16 update over one byte, LSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPolyRefl;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[hdl/srfc_in_stage.sv]
// Input register of the frame checker: holds one request until the
// frame tracker takes it. Depends on srfc_pkg.
module srfc_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  srfc_pkg::srfc_item_type req_item,
   input  logic                   advance,
   output logic                   item_valid,
   output srfc_pkg::srfc_item_type item
);
   import srfc_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   srfc_item_type item_ff;
   logic          load;

   // The register takes a new request when it is empty or is being drained.
   assign load      = !valid_ff || advance;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hdl/srfc_frame_track.sv]
// Frame position, running CRC and reading bytes; forms the result when
// the last byte of a frame is processed. Depends on srfc_pkg.
module srfc_frame_track (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     process,
   input  srfc_pkg::srfc_item_type   item,
   output logic                     result_valid,
   output srfc_pkg::srfc_result_type result
);
   import srfc_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [3:0]  pos_ff;
   logic [3:0]  pos_in;
   logic [7:0]  reading_ff [4];
   logic [7:0]  check_low_ff;

   logic [3:0]  pos_eff;
   logic [15:0] crc_eff;
   logic        active;
   logic [1:0]  slot;
   logic [15:0] expect_crc;
   logic [15:0] magnitude;
   logic [15:0] temp_value;

   // A start mark restarts the frame at byte 0 with a fresh CRC.
   assign pos_eff = item.frame_start ? 4'd0 : pos_ff;
   assign crc_eff = item.frame_start ? CrcInit : crc_ff;
   assign active  = (pos_eff < FrameLen);
   assign slot    = pos_eff[1:0] - FirstReading[1:0];

   // Next position and CRC.
   always_comb begin
      pos_in = pos_eff;
      crc_in = crc_eff;
      if (active) begin
         pos_in = pos_eff + 4'd1;
         if (pos_eff < CrcSpan) begin
            crc_in = crc_byte(crc_eff, item.rx_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CrcInit;
         pos_ff <= FrameLen;
      end else if (process) begin
         crc_ff <= crc_in;
         pos_ff <= pos_in;
      end
   end

   // Humidity and temperature bytes, then the low CRC byte.
   always_ff @(posedge clock) begin
      if (process && active && pos_eff >= FirstReading && pos_eff < CrcSpan) begin
         reading_ff[slot] <= item.rx_byte;
      end
      if (process && pos_eff == CrcSpan) begin
         check_low_ff <= item.rx_byte;
      end
   end

   // Result formation on the last byte of the frame.
   assign expect_crc = {item.rx_byte, check_low_ff};
   assign magnitude  = {1'b0, reading_ff[2][6:0], reading_ff[3]};
   assign temp_value = reading_ff[2][SignBit] ? (16'd0 - magnitude) : magnitude;

   always_comb begin
      result_valid = process && (pos_eff == LastByte);
      if (expect_crc != crc_eff) begin
         result.humidity_tenths    = 16'd0;
         result.temperature_tenths = 16'sd0;
         result.frame_status       = FrameBadCrc;
      end else begin
         result.humidity_tenths    = {reading_ff[0], reading_ff[1]};
         result.temperature_tenths = signed'(temp_value);
         result.frame_status       = FrameOk;
      end
   end

endmodule

[hdl/srfc_out_stage.sv]
// Result register of the frame checker: holds one result until the
// receiver takes it. Depends on srfc_pkg.
module srfc_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      result_valid,
   input  srfc_pkg::srfc_result_type  result,
   output logic                      out_free,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output srfc_pkg::srfc_result_type  rsp_result
);
   import srfc_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   srfc_result_type result_ff;

   // Room for a new result when empty or when the current one leaves now.
   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = out_free ? result_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && result_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

[hdl/sensor_reply_frame_checker_core.sv]
// Checks 8-byte sensor reply frames one byte per request.
// Depends on srfc_pkg, srfc_in_stage, srfc_frame_track and srfc_out_stage.
//
// Usage:
//   The request channel (req_valid, req_stall, req_rx_byte, req_frame_start)
//   carries one frame byte per request; req_frame_start marks byte 0.
//   CRC-16/Modbus runs over bytes 0 to 5 and is compared with bytes 6
//   (low) and 7 (high). On byte 7 one response is sent on the rsp_ channel
//   with humidity and temperature in tenths and the frame status; a bad
//   CRC gives status 1 and zero readings. Bytes outside a frame and a
//   partial frame cut off by a new start give no response.
//   Byte 7 sits in the input register while the compare with the stored
//   CRC forms the response, which is written into the response register
//   and raises rsp_valid. One request is accepted every cycle while the
//   receiver keeps up; the single-byte CRC update between the two
//   registers sets that figure. After reset both registers are empty and
//   the checker waits for a start mark. While rsp_stall holds a waiting
//   response, the input register fills and then req_stall rises until
//   the response is taken.
module sensor_reply_frame_checker_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_humidity_tenths,
   output logic signed [15:0] rsp_temperature_tenths,
   output logic               rsp_frame_status
);
   import srfc_pkg::*;

   srfc_item_type   req_item;
   srfc_item_type   item;
   logic            item_valid;
   logic            out_free;
   logic            process;
   logic            result_valid;
   srfc_result_type result;
   srfc_result_type rsp_result;

   assign req_item.rx_byte     = req_rx_byte;
   assign req_item.frame_start = req_frame_start;

   // A held byte is processed whenever the response register has room.
   assign process = item_valid && out_free;

   srfc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   srfc_frame_track u_frame_track (
      .clock        (clock),
      .reset        (reset),
      .process      (process),
      .item         (item),
      .result_valid (result_valid),
      .result       (result)
   );

   srfc_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .out_free     (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result   (rsp_result)
   );

   assign rsp_humidity_tenths    = rsp_result.humidity_tenths;
   assign rsp_temperature_tenths = rsp_result.temperature_tenths;
   assign rsp_frame_status       = rsp_result.frame_status;

endmodule
